// ===== rtl/core/wns_pkg.sv =====
// ---------------------------------------------------------------------------
// wns_pkg
// Types and codes shared by the window neighbor search unit and its compare stage.
// ---------------------------------------------------------------------------
`default_nettype none

package wns_pkg;

  localparam int SLOT_W      = 6;
  localparam int VALUE_W     = 32;
  localparam int ENTRIES_W   = 7;
  localparam int MAX_RESULTS = 64;
  // wide enough for any table index, slot or entry count
  localparam int IDX_CMP_W   = 13;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    CFG_LOWER_OFFSET   = 2'd0,
    CFG_UPPER_OFFSET   = 2'd1,
    CFG_ENTRIES_IN_USE = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_FLUSH,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic                      action;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] sample_value;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] match_slot;
    logic              found;
    logic              last;
  } out_word_t;

  // one slot under test, or one slot that passed the window test
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } scan_tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/wns_cell.sv =====
// ---------------------------------------------------------------------------
// wns_cell
// One table slot of the sample ring: loads a sample or takes its neighbor's.
// ---------------------------------------------------------------------------
`default_nettype none

module wns_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   shift_en,
  input  wire logic                   load_en,
  input  wire logic [SAMPLE_BITS-1:0] shift_in,
  input  wire logic [SAMPLE_BITS-1:0] load_data,
  output logic      [SAMPLE_BITS-1:0] sample
);

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] sample_nxt;

  always_comb begin
    sample_nxt = sample_r;
    if (shift_en) begin
      sample_nxt = shift_in;
    end else if (load_en) begin
      sample_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

  assign sample = sample_r;

endmodule

`default_nettype wire

// ===== rtl/core/wns_window_cmp.sv =====
// ---------------------------------------------------------------------------
// wns_window_cmp
// Window test: registered difference, then bound compare.
// ---------------------------------------------------------------------------
`default_nettype none

module wns_window_cmp
  import wns_pkg::*;
#(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scan_tag_t                     req,
  input  wire logic signed [SAMPLE_BITS-1:0] head,
  input  wire logic signed [SAMPLE_BITS-1:0] centre,
  input  wire logic signed [VALUE_W-1:0]     lower,
  input  wire logic signed [VALUE_W-1:0]     upper,
  output scan_tag_t                          hit
);

  // difference is at least one bit wider than a sample, bounds fit as well
  localparam int CW = (SAMPLE_BITS + 1 > VALUE_W + 1) ? SAMPLE_BITS + 1 : VALUE_W + 1;

  logic signed [CW-1:0] diff_r;
  logic signed [CW-1:0] diff_nxt;
  scan_tag_t            tag_r;
  logic signed [CW-1:0] lower_ext;
  logic signed [CW-1:0] upper_ext;

  always_comb begin
    diff_nxt  = CW'(head) - CW'(centre);
    lower_ext = CW'(lower);
    upper_ext = CW'(upper);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= req.valid;
    end
    tag_r.idx <= req.idx;
    diff_r    <= diff_nxt;
  end

  always_comb begin
    hit.idx   = tag_r.idx;
    hit.valid = tag_r.valid && (diff_r >= lower_ext) && (diff_r < upper_ext);
  end

endmodule

`default_nettype wire

// ===== rtl/core/window_neighbor_search_unit.sv =====
// ---------------------------------------------------------------------------
// window_neighbor_search_unit
// Table of signed fixed-point samples searched for slots whose difference
// to a centre slot lies in [lower_offset, upper_offset).
// ---------------------------------------------------------------------------
// sequence: a load gives no result; a query keeps busy high through the
//   find, scan, flush and final states, results leave in ascending slot
//   order and the final one (last=1) is strobed once busy has fallen
// a new query is accepted only once busy has fallen, after two full turns
//   of the sample ring (one to pick up the centre, one to scan), a flush
//   of the compare stage and the final state that produces the final word
// reset: synchronous, active low; offsets and entry count take their reset
//   values, table contents stay undefined until loaded
// results are strobed for a single cycle and cannot be stalled
`default_nettype none

module window_neighbor_search_unit
  import wns_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // item channel
  input  wire logic       start,
  output logic            busy,
  input  wire in_word_t   in_word,
  // result channel
  output logic            out_strobe,
  output out_word_t       out_word,
  // configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire cfg_index_t cfg_index,
  input  wire logic [VALUE_W-1:0] cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // configuration registers
  logic signed [VALUE_W-1:0] lower_r;
  logic signed [VALUE_W-1:0] upper_r;
  logic [ENTRIES_W-1:0]      entries_r;

  // control
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic signed [SAMPLE_BITS-1:0] centre_r, centre_nxt;

  // pending match, held back until we know whether it is the last one
  logic                 pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]    pend_idx_r, pend_idx_nxt;

  // output word register
  logic                 out_strobe_r, out_strobe_nxt;
  out_word_t            out_word_r, out_word_nxt;

  logic                 accept;
  logic                 load_accept;
  logic                 shift_en;
  logic                 turn_done;
  logic                 slot_ok;
  logic                 in_use;
  logic [SAMPLE_BITS-1:0] load_data;
  logic signed [63:0]   load_ext;
  scan_tag_t            cmp_req;
  scan_tag_t            hit;

  // ring of sample cells; cell 0 is the head read by the compare stage
  logic [SAMPLE_BITS-1:0] ring [TABLE_DEPTH];

  assign accept      = start && !busy;
  assign load_accept = accept && (in_word.action == ACT_LOAD);
  assign cfg_ready   = 1'b1;

  // sample sign-extended to 64 bits then wrapped to the stored width
  assign load_ext  = 64'(in_word.sample_value);
  assign load_data = load_ext[SAMPLE_BITS-1:0];

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    logic cell_load;
    // ring is parked (cell k holds slot k) whenever idle
    assign cell_load = load_accept &&
                       (IDX_CMP_W'(in_word.slot) == IDX_CMP_W'(k));
    wns_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .load_en   (cell_load),
      .shift_in  (ring[(k + 1) % TABLE_DEPTH]),
      .load_data (load_data),
      .sample    (ring[k])
    );
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r   <= '0;
      upper_r   <= VALUE_W'(65536);
      entries_r <= ENTRIES_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LOWER_OFFSET:   lower_r   <= cfg_data;
        CFG_UPPER_OFFSET:   upper_r   <= cfg_data;
        CFG_ENTRIES_IN_USE: entries_r <= cfg_data[ENTRIES_W-1:0];
        default: ;
      endcase
    end
  end

  assign turn_done = (cnt_r == IDX_W'(TABLE_DEPTH - 1));
  assign slot_ok   = IDX_CMP_W'(slot_r) < IDX_CMP_W'(TABLE_DEPTH);
  // slot under test must be below the entry count and the result limit
  assign in_use    = (IDX_CMP_W'(cnt_r) < IDX_CMP_W'(entries_r)) &&
                     (IDX_CMP_W'(cnt_r) < IDX_CMP_W'(MAX_RESULTS));

  // sequencer: find the centre in one ring turn, scan in the next, then flush and finish
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    slot_nxt    = slot_r;
    centre_nxt  = centre_r;
    shift_en    = 1'b0;
    cmp_req.valid = 1'b0;
    cmp_req.idx   = SLOT_W'(cnt_r);

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_word.action == ACT_QUERY)) begin
          state_nxt = ST_FIND;
          slot_nxt  = in_word.slot;
          cnt_nxt   = '0;
        end
      end
      ST_FIND: begin
        shift_en = 1'b1;
        if (IDX_CMP_W'(cnt_r) == IDX_CMP_W'(slot_r)) begin
          centre_nxt = ring[0];
        end
        if (turn_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        shift_en      = 1'b1;
        cmp_req.valid = slot_ok && in_use;
        if (turn_done) begin
          cnt_nxt   = '0;
          state_nxt = ST_FLUSH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FLUSH: begin
        // compare stage finishes the last slot here
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        // only the held-back match (or the empty answer) is left
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  wns_window_cmp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (cmp_req),
    .head   (ring[0]),
    .centre (centre_r),
    .lower  (lower_r),
    .upper  (upper_r),
    .hit    (hit)
  );

  // result collector: each new hit releases the one before it
  always_comb begin
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;

    if (accept && (in_word.action == ACT_QUERY)) begin
      pend_v_nxt = 1'b0;
    end

    if (hit.valid) begin
      if (pend_v_r) begin
        out_strobe_nxt          = 1'b1;
        out_word_nxt.match_slot = pend_idx_r;
        out_word_nxt.found      = 1'b1;
        out_word_nxt.last       = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_idx_nxt = hit.idx;
    end

    if (state_r == ST_FINAL) begin
      // compare stage is empty by now, the held match is the final word
      out_strobe_nxt = 1'b1;
      out_word_nxt.last = 1'b1;
      if (pend_v_r) begin
        out_word_nxt.match_slot = pend_idx_r;
        out_word_nxt.found      = 1'b1;
      end else begin
        out_word_nxt.match_slot = '0;
        out_word_nxt.found      = 1'b0;
      end
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      pend_v_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_v_r     <= pend_v_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    slot_r     <= slot_nxt;
    centre_r   <= centre_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

`default_nettype wire
